// ----- rtl/psrf_pkg.sv -----
// Shared types, codes and packing helpers for the packet slot ring FIFO.
package psrf_pkg;

  // Widest slot index carried in a command (SLOT_COUNT up to 1024).
  localparam int unsigned SLOT_IDX_W = 10;
  // Command queue between front and back.
  localparam int unsigned CMD_Q_DEPTH = 2;
  // Outstanding pops: queue entries plus the one in the back.
  localparam int unsigned POP_CNT_W = 2;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_DROP  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2,
    STATUS_BAD_LEN = 2'd3
  } status_e;

  typedef enum logic {
    CMD_SINGLE = 1'b0,
    CMD_POP    = 1'b1
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_LEN    = 2'd1,
    BK_STREAM = 2'd2
  } back_state_e;

  typedef struct packed {
    cmd_kind_e             kind;
    status_e               status;
    logic [5:0]            len;
    logic [SLOT_IDX_W-1:0] slot;
    logic [3:0]            used;
    logic [3:0]            peak;
    logic [31:0]           drops;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  out_byte;
    logic [5:0]  len;
    logic        last;
    logic [3:0]  used;
    logic [3:0]  peak;
    logic [31:0] drops;
  } res_t;

  // Lay out a result on the output bus, first field lowest.
  function automatic logic [OUT_DATA_W-1:0] pack_res(input res_t r);
    pack_res = {r.drops, r.peak, r.used, r.len, r.out_byte, r.status};
  endfunction

endpackage

// ----- rtl/psrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module psrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/psrf_front.sv -----
// Front end: accept requests, keep ring pointers and counters, issue commands.
module psrf_front #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned SLOT_BYTES = 32,
  localparam int unsigned SW  = $clog2(SLOT_COUNT),
  localparam int unsigned GW  = $clog2(SLOT_BYTES + 2),
  localparam int unsigned LW  = $clog2(SLOT_BYTES + 1),
  localparam int unsigned BIW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic [1:0]           s_axis_tuser,
  input  logic                 q_full_i,
  output logic                 cmd_valid_o,
  output psrf_pkg::cmd_t       cmd_o,
  input  logic                 pop_done_i,
  output logic                 byte_we_o,
  output logic [SW+BIW-1:0]    byte_waddr_o,
  output logic [7:0]           byte_wdata_o,
  output logic                 len_we_o,
  output logic [SW-1:0]        len_waddr_o,
  output logic [LW-1:0]        len_wdata_o
);

  logic [SW-1:0]                  rs_q, rs_d, ws_q, ws_d, wm_q, wm_d;
  logic [SW-1:0]                  rs_inc, ws_inc, used_d;
  logic [SW:0]                    used_ext;
  logic [GW-1:0]                  g_q, g_d, g_new;
  logic [31:0]                    drops_q, drops_d;
  logic [psrf_pkg::POP_CNT_W-1:0] pops_q, pops_d;
  logic                           accept, fits, overlong, ring_full, commit, pop_issue;
  psrf_pkg::op_e                  op;
  psrf_pkg::cmd_kind_e            cmd_kind;
  psrf_pkg::status_e              cmd_status;
  logic [5:0]                     cmd_len;

  assign op            = psrf_pkg::op_e'(s_axis_tuser);
  // Hold pushes while a pop still reads the byte store.
  assign s_axis_tready = !q_full_i && !(op == psrf_pkg::OP_PUSH && pops_q != '0);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign rs_inc = (rs_q == SW'(SLOT_COUNT - 1)) ? '0 : rs_q + 1'b1;
  assign ws_inc = (ws_q == SW'(SLOT_COUNT - 1)) ? '0 : ws_q + 1'b1;

  assign fits      = g_q < GW'(SLOT_BYTES);
  assign g_new     = fits ? g_q + 1'b1 : GW'(SLOT_BYTES + 1);
  assign overlong  = g_new > GW'(SLOT_BYTES);
  assign ring_full = ws_inc == rs_q;

  always_comb begin
    rs_d        = rs_q;
    ws_d        = ws_q;
    g_d         = g_q;
    drops_d     = drops_q;
    commit      = 1'b0;
    pop_issue   = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_kind    = psrf_pkg::CMD_SINGLE;
    cmd_status  = psrf_pkg::STATUS_OK;
    cmd_len     = '0;
    if (accept) begin
      case (op)
        psrf_pkg::OP_PUSH: begin
          g_d = g_new;
          if (s_axis_tlast) begin
            g_d         = '0;
            cmd_valid_o = 1'b1;
            if (overlong) begin
              cmd_status = psrf_pkg::STATUS_BAD_LEN;
            end else if (ring_full) begin
              drops_d    = drops_q + 32'd1;
              cmd_status = psrf_pkg::STATUS_DROPPED;
              cmd_len    = 6'(g_new);
            end else begin
              commit  = 1'b1;
              ws_d    = ws_inc;
              cmd_len = 6'(g_new);
            end
          end
        end
        psrf_pkg::OP_POP: begin
          cmd_valid_o = 1'b1;
          if (rs_q == ws_q) begin
            cmd_status = psrf_pkg::STATUS_EMPTY;
          end else begin
            pop_issue = 1'b1;
            cmd_kind  = psrf_pkg::CMD_POP;
            rs_d      = rs_inc;
          end
        end
        psrf_pkg::OP_DROP: begin
          cmd_valid_o = 1'b1;
          drops_d     = drops_q + 32'd1;
        end
        psrf_pkg::OP_QUERY: begin
          cmd_valid_o = 1'b1;
        end
        default: begin
          cmd_valid_o = 1'b1;
        end
      endcase
    end
  end

  // Occupancy and watermark after this step.
  always_comb begin
    if (ws_d >= rs_d) begin
      used_ext = {1'b0, ws_d} - {1'b0, rs_d};
    end else begin
      used_ext = (SW+1)'(SLOT_COUNT) - {1'b0, rs_d} + {1'b0, ws_d};
    end
    used_d = used_ext[SW-1:0];
    wm_d   = (commit && used_d > wm_q) ? used_d : wm_q;
  end

  // Command fields in declaration order: kind, status, len, slot, used, peak, drops.
  assign cmd_o = {cmd_kind, cmd_status, cmd_len, psrf_pkg::SLOT_IDX_W'(rs_q),
                  4'(used_d), 4'(wm_d), drops_d};

  always_comb begin
    pops_d = pops_q;
    if (pop_issue && !pop_done_i) begin
      pops_d = pops_q + 1'b1;
    end else if (!pop_issue && pop_done_i) begin
      pops_d = pops_q - 1'b1;
    end
  end

  assign byte_we_o    = accept && op == psrf_pkg::OP_PUSH && fits;
  assign byte_waddr_o = {ws_q, g_q[BIW-1:0]};
  assign byte_wdata_o = s_axis_tdata;
  assign len_we_o     = commit;
  assign len_waddr_o  = ws_q;
  assign len_wdata_o  = g_new[LW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q    <= '0;
      ws_q    <= '0;
      wm_q    <= '0;
      g_q     <= '0;
      drops_q <= '0;
      pops_q  <= '0;
    end else begin
      rs_q    <= rs_d;
      ws_q    <= ws_d;
      wm_q    <= wm_d;
      g_q     <= g_d;
      drops_q <= drops_d;
      pops_q  <= pops_d;
    end
  end

endmodule

// ----- rtl/psrf_cmd_q.sv -----
// Two-entry command queue between the front and the back.
module psrf_cmd_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  psrf_pkg::cmd_t data_i,
  output logic           full_o,
  output logic           valid_o,
  output psrf_pkg::cmd_t data_o,
  input  logic           pop_i
);

  localparam int unsigned PW = $clog2(psrf_pkg::CMD_Q_DEPTH);

  psrf_pkg::cmd_t ent_q [psrf_pkg::CMD_Q_DEPTH];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [PW:0]    cnt_q;

  assign full_o  = cnt_q == (PW+1)'(psrf_pkg::CMD_Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/psrf_back.sv -----
// Back end: run commands, stream popped bytes, buffer results for the output.
module psrf_back #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned SLOT_BYTES = 32,
  localparam int unsigned SW  = $clog2(SLOT_COUNT),
  localparam int unsigned LW  = $clog2(SLOT_BYTES + 1),
  localparam int unsigned BIW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  psrf_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  output logic [SW-1:0]                       len_raddr_o,
  input  logic [LW-1:0]                       len_rdata_i,
  output logic [SW+BIW-1:0]                   byte_raddr_o,
  input  logic [7:0]                          byte_rdata_i,
  output logic                                pop_done_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [psrf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast
);

  psrf_pkg::back_state_e state_q, state_d;
  psrf_pkg::cmd_t        cur_q;
  logic [LW-1:0]         len_q, idx_q;
  logic                  idx_last, room, take;
  logic                  issue_single, issue_byte;
  logic [1:0]            room_cnt;

  // Result read stage (waits for the registered byte store read).
  logic                  s1_valid_q, s1_ram_q;
  psrf_pkg::res_t        s1_q, s1_d;

  // Output buffer.
  psrf_pkg::res_t        ent_q [2];
  psrf_pkg::res_t        land;
  logic                  wptr_q, rptr_q;
  logic [1:0]            occ_q;

  assign take     = m_axis_tvalid && m_axis_tready;
  assign room_cnt = occ_q + {1'b0, s1_valid_q} - {1'b0, take};
  assign room     = room_cnt < 2'd2;
  assign idx_last = (idx_q + 1'b1) == len_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      psrf_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_i.kind == psrf_pkg::CMD_POP) begin
          state_d = psrf_pkg::BK_LEN;
        end
      end
      psrf_pkg::BK_LEN: begin
        state_d = psrf_pkg::BK_STREAM;
      end
      psrf_pkg::BK_STREAM: begin
        if (room && idx_last) begin
          state_d = psrf_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = psrf_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop_o    = 1'b0;
    issue_single = 1'b0;
    issue_byte   = 1'b0;
    case (state_q)
      psrf_pkg::BK_IDLE: begin
        cmd_pop_o    = cmd_valid_i && (cmd_i.kind == psrf_pkg::CMD_POP || room);
        issue_single = cmd_valid_i && cmd_i.kind == psrf_pkg::CMD_SINGLE && room;
      end
      psrf_pkg::BK_STREAM: begin
        issue_byte = room;
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  assign pop_done_o   = issue_byte && idx_last;
  assign len_raddr_o  = cmd_i.slot[SW-1:0];
  assign byte_raddr_o = {cur_q.slot[SW-1:0], idx_q[BIW-1:0]};

  always_comb begin
    if (issue_single) begin
      s1_d.status = cmd_i.status;
      s1_d.len    = cmd_i.len;
      s1_d.last   = 1'b1;
      s1_d.used   = cmd_i.used;
      s1_d.peak   = cmd_i.peak;
      s1_d.drops  = cmd_i.drops;
    end else begin
      s1_d.status = psrf_pkg::STATUS_OK;
      s1_d.len    = 6'(len_q);
      s1_d.last   = idx_last;
      s1_d.used   = cur_q.used;
      s1_d.peak   = cur_q.peak;
      s1_d.drops  = cur_q.drops;
    end
    s1_d.out_byte = '0;
  end

  // Fill in the byte as the read lands.
  always_comb begin
    land          = s1_q;
    land.out_byte = s1_ram_q ? byte_rdata_i : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == psrf_pkg::BK_IDLE && cmd_pop_o) begin
      cur_q <= cmd_i;
    end
    if (state_q == psrf_pkg::BK_LEN) begin
      len_q <= len_rdata_i;
    end
    if (issue_single || issue_byte) begin
      s1_q     <= s1_d;
      s1_ram_q <= issue_byte;
    end
    if (s1_valid_q) begin
      ent_q[wptr_q] <= land;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= psrf_pkg::BK_IDLE;
      idx_q      <= '0;
      s1_valid_q <= 1'b0;
      wptr_q     <= 1'b0;
      rptr_q     <= 1'b0;
      occ_q      <= '0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= issue_single || issue_byte;
      if (state_q == psrf_pkg::BK_LEN) begin
        idx_q <= '0;
      end else if (issue_byte) begin
        idx_q <= idx_q + 1'b1;
      end
      if (s1_valid_q) begin
        wptr_q <= ~wptr_q;
      end
      if (take) begin
        rptr_q <= ~rptr_q;
      end
      occ_q <= occ_q + {1'b0, s1_valid_q} - {1'b0, take};
    end
  end

  assign m_axis_tvalid = occ_q != '0;
  assign m_axis_tdata  = psrf_pkg::pack_res(ent_q[rptr_q]);
  assign m_axis_tlast  = ent_q[rptr_q].last;

endmodule

// ----- rtl/packet_slot_ring_fifo.sv -----
// Packet slot ring FIFO: top level joining front, command queue, back and stores.
// Path: a request that yields one result passes the command queue, read stage and
//   output buffer; a pop reads its length, then streams one byte per cycle unless stalled.
// Throughput: one request per cycle, set by the front, while the command queue has room;
//   pushes wait while a pop reads the byte store; the back drains one result per cycle unless stalled.
// Reset (rst_ni low, asynchronous): pointers, counters, watermark and all queues
//   clear at once; the byte and length stores are not cleared and need no sweep.
module packet_slot_ring_fifo #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned SLOT_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] push_byte
  input  logic        s_axis_tlast,   // push_last
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [9:2] out_byte, [15:10] packet_length, [19:16] slots_used,
  // [23:20] peak_used, [55:24] drop_count
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast    // out_last
);

  localparam int unsigned SW  = $clog2(SLOT_COUNT);
  localparam int unsigned LW  = $clog2(SLOT_BYTES + 1);
  localparam int unsigned BIW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  // Each slot owns a power-of-two window of the byte store.
  localparam int unsigned BYTE_DEPTH = SLOT_COUNT * (2 ** BIW);

  psrf_pkg::cmd_t     fq_cmd, qb_cmd;
  logic               fq_valid, q_full, qb_valid, qb_pop, pop_done;
  logic               byte_we, len_we;
  logic [SW+BIW-1:0]  byte_waddr, byte_raddr;
  logic [7:0]         byte_wdata, byte_rdata;
  logic [SW-1:0]      len_waddr, len_raddr;
  logic [LW-1:0]      len_wdata, len_rdata;

  // Front: take each request, move the ring pointers and counters, and post
  // a command carrying the post-step counter snapshot.
  psrf_front #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .q_full_i     (q_full),
    .cmd_valid_o  (fq_valid),
    .cmd_o        (fq_cmd),
    .pop_done_i   (pop_done),
    .byte_we_o    (byte_we),
    .byte_waddr_o (byte_waddr),
    .byte_wdata_o (byte_wdata),
    .len_we_o     (len_we),
    .len_waddr_o  (len_waddr),
    .len_wdata_o  (len_wdata)
  );

  // Decouple the front from output stalls.
  psrf_cmd_q u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fq_valid),
    .data_i (fq_cmd),
    .full_o (q_full),
    .valid_o(qb_valid),
    .data_o (qb_cmd),
    .pop_i  (qb_pop)
  );

  // Packet bytes, one window per slot.
  psrf_ram #(
    .WIDTH(8),
    .DEPTH(BYTE_DEPTH)
  ) u_byte_ram (
    .clk_i  (clk_i),
    .we_i   (byte_we),
    .waddr_i(byte_waddr),
    .wdata_i(byte_wdata),
    .raddr_i(byte_raddr),
    .rdata_o(byte_rdata)
  );

  // Committed length of each slot.
  psrf_ram #(
    .WIDTH(LW),
    .DEPTH(SLOT_COUNT)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (len_we),
    .waddr_i(len_waddr),
    .wdata_i(len_wdata),
    .raddr_i(len_raddr),
    .rdata_o(len_rdata)
  );

  // Back: turn each command into one result, or a byte stream for a pop.
  psrf_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (qb_valid),
    .cmd_i        (qb_cmd),
    .cmd_pop_o    (qb_pop),
    .len_raddr_o  (len_raddr),
    .len_rdata_i  (len_rdata),
    .byte_raddr_o (byte_raddr),
    .byte_rdata_i (byte_rdata),
    .pop_done_o   (pop_done),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ----- rtl/psrf_checker.sv -----
// Port-level assertions for the packet slot ring FIFO, bound to the top level.
module psrf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled result request stays up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result request dropped while stalled");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // Only a popped byte carries data; every other status is a lone final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != psrf_pkg::STATUS_OK
      |-> m_axis_tdata[9:2] == 8'd0 && m_axis_tlast)
    else $error("non-ok result carries data or is not final");

  // An empty pop reports no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == psrf_pkg::STATUS_EMPTY
      |-> m_axis_tdata[15:10] == 6'd0)
    else $error("empty pop reports a length");

endmodule

bind packet_slot_ring_fifo psrf_checker u_checker (.*);

// ----- tb/tb_packet_slot_ring_fifo.sv -----
// Self-checking testbench for the packet slot ring FIFO: directed and random requests.
`timescale 1ns / 100ps

module tb_packet_slot_ring_fifo;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned SLOT_SZ    = 32;
  localparam int unsigned STALL_LIMIT = 2000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic [1:0]  s_axis_tuser  = psrf_pkg::OP_QUERY;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  packet_slot_ring_fifo #(
    .SLOT_COUNT(SLOTS),
    .SLOT_BYTES(SLOT_SZ)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Shadow copy of the ring.
  logic [7:0]  ring_mem [SLOTS][SLOT_SZ];
  logic [5:0]  ring_len [SLOTS];
  logic [3:0]  rd_slot     = '0;
  logic [3:0]  wr_slot     = '0;
  logic [3:0]  peak_slots  = '0;
  logic [31:0] drop_total  = '0;
  int unsigned gathered    = 0;

  psrf_pkg::res_t ring_results_q[$];
  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned send_idle_pct = 23;
  int unsigned recv_stall_pct = 56;
  int unsigned quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic psrf_pkg::res_t ring_result(psrf_pkg::status_e st, logic [7:0] data,
                                                 logic [5:0] len, logic last);
    psrf_pkg::res_t r;
    r.status   = st;
    r.out_byte = data;
    r.len      = len;
    r.last     = last;
    r.used     = wr_slot - rd_slot;
    r.peak     = peak_slots;
    r.drops    = drop_total;
    return r;
  endfunction

  // Advance the shadow ring by one request and queue the results it yields.
  function void ring_apply(psrf_pkg::op_e op, logic [7:0] data, logic last);
    logic [5:0] len;
    logic [3:0] slot;
    logic [3:0] next_slot;
    case (op)
      psrf_pkg::OP_PUSH: begin
        if (gathered < SLOT_SZ) begin
          ring_mem[wr_slot][gathered] = data;
          gathered++;
        end else begin
          gathered = SLOT_SZ + 1;
        end
        if (last) begin
          len       = 6'(gathered);
          gathered  = 0;
          next_slot = wr_slot + 4'd1;
          if (len > SLOT_SZ) begin
            ring_results_q.push_back(ring_result(psrf_pkg::STATUS_BAD_LEN, 8'h00, 6'd0,
                                                 1'b1));
          end else if (next_slot == rd_slot) begin
            drop_total++;
            ring_results_q.push_back(ring_result(psrf_pkg::STATUS_DROPPED, 8'h00, len,
                                                 1'b1));
          end else begin
            ring_len[wr_slot] = len;
            wr_slot = next_slot;
            if (4'(wr_slot - rd_slot) > peak_slots) peak_slots = wr_slot - rd_slot;
            ring_results_q.push_back(ring_result(psrf_pkg::STATUS_OK, 8'h00, len, 1'b1));
          end
        end
      end
      psrf_pkg::OP_POP: begin
        if (rd_slot == wr_slot) begin
          ring_results_q.push_back(ring_result(psrf_pkg::STATUS_EMPTY, 8'h00, 6'd0, 1'b1));
        end else begin
          slot    = rd_slot;
          len     = ring_len[slot];
          rd_slot = rd_slot + 4'd1;
          for (int i = 0; i < len; i++) begin
            ring_results_q.push_back(ring_result(psrf_pkg::STATUS_OK, ring_mem[slot][i],
                                                 len, i == len - 1));
          end
        end
      end
      psrf_pkg::OP_DROP: begin
        drop_total++;
        ring_results_q.push_back(ring_result(psrf_pkg::STATUS_OK, 8'h00, 6'd0, 1'b1));
      end
      default: begin
        ring_results_q.push_back(ring_result(psrf_pkg::STATUS_OK, 8'h00, 6'd0, 1'b1));
      end
    endcase
  endfunction

  task automatic send_req(psrf_pkg::op_e op, logic [7:0] data, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    ring_apply(op, data, last);
    items_sent++;
  endtask

  task automatic send_packet(int unsigned n_bytes);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      send_req(psrf_pkg::OP_PUSH, 8'($urandom), i == n_bytes - 1);
    end
  endtask

  task automatic test_empty_and_query();
    send_req(psrf_pkg::OP_POP, 8'h00, 1'b0);
    send_req(psrf_pkg::OP_QUERY, 8'hFF, 1'b1);
  endtask

  task automatic test_byte_extremes();
    send_req(psrf_pkg::OP_PUSH, 8'h00, 1'b0);
    send_req(psrf_pkg::OP_PUSH, 8'hFF, 1'b1);
    send_req(psrf_pkg::OP_PUSH, 8'hA5, 1'b1);
    send_req(psrf_pkg::OP_POP, 8'h5A, 1'b1);
    send_req(psrf_pkg::OP_POP, 8'h00, 1'b0);
    send_req(psrf_pkg::OP_POP, 8'hFF, 1'b0);
  endtask

  task automatic test_external_drop();
    send_req(psrf_pkg::OP_DROP, 8'h00, 1'b0);
    send_req(psrf_pkg::OP_DROP, 8'hFF, 1'b1);
    send_req(psrf_pkg::OP_QUERY, 8'h00, 1'b0);
  endtask

  task automatic test_pop_mid_push();
    send_req(psrf_pkg::OP_PUSH, 8'h5A, 1'b0);
    send_req(psrf_pkg::OP_POP, 8'h00, 1'b0);
    send_req(psrf_pkg::OP_PUSH, 8'h3C, 1'b1);
    send_req(psrf_pkg::OP_POP, 8'h00, 1'b0);
  endtask

  task automatic test_length_limits();
    send_packet(SLOT_SZ);
    send_packet(SLOT_SZ + 1);
    send_req(psrf_pkg::OP_POP, 8'($urandom), 1'($urandom));
  endtask

  task automatic test_ring_full();
    for (int unsigned i = 0; i < SLOTS; i++) send_packet(1);
    for (int unsigned i = 0; i < SLOTS; i++) begin
      send_req(psrf_pkg::OP_POP, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        pick = $urandom_range(99);
        n = (pick < 78) ? $urandom_range(1, 6) :
            (pick < 88) ? $urandom_range(7, SLOT_SZ - 1) :
            (pick < 95) ? SLOT_SZ : $urandom_range(SLOT_SZ + 1, SLOT_SZ + 2);
        for (int unsigned i = 0; i < n; i++) begin
          if ($urandom_range(19) == 0) begin
            send_req(psrf_pkg::op_e'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
          end
          send_req(psrf_pkg::OP_PUSH, 8'($urandom), i == n - 1);
        end
      end else if (pick < 80) begin
        send_req(psrf_pkg::OP_POP, 8'($urandom), 1'($urandom));
      end else if (pick < 87) begin
        send_req(psrf_pkg::OP_DROP, 8'($urandom), 1'($urandom));
      end else if (pick < 93) begin
        send_req(psrf_pkg::OP_QUERY, 8'($urandom), 1'($urandom));
      end else begin
        send_req(psrf_pkg::op_e'($urandom_range(3)), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    psrf_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (ring_results_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = ring_results_q.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tdata[1:0]));
        check_field("out_byte", 32'(want.out_byte), 32'(m_axis_tdata[9:2]));
        check_field("packet_length", 32'(want.len), 32'(m_axis_tdata[15:10]));
        check_field("out_last", 32'(want.last), 32'(m_axis_tlast));
        check_field("slots_used", 32'(want.used), 32'(m_axis_tdata[19:16]));
        check_field("peak_used", 32'(want.peak), 32'(m_axis_tdata[23:20]));
        check_field("drop_count", want.drops, m_axis_tdata[55:24]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_query();
    test_byte_extremes();
    test_external_drop();
    test_pop_mid_push();
    test_length_limits();
    test_ring_full();
    test_random_traffic(55);
    send_idle_pct  = 56;
    recv_stall_pct = 23;
    test_random_traffic(55);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(55);
    s_axis_tvalid <= 1'b0;
    while (ring_results_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
